[sv/efcb_pkg.sv]
// shared types, frame constants and crc helper for the event frame builder
`default_nettype none
package efcb_pkg;

    localparam int unsigned BodyLen  = 28;
    localparam int unsigned FrameLen = 30;
    localparam int unsigned PosW     = 5;

    localparam logic [7:0]  SYNC0       = 8'hA5;
    localparam logic [7:0]  SYNC1       = 8'h5A;
    localparam logic [7:0]  VERSION     = 8'h01;
    localparam logic [7:0]  PAYLOAD_LEN = 8'd24;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic [PosW-1:0] POS_CRC_LO = PosW'(BodyLen);
    localparam logic [PosW-1:0] POS_LAST   = PosW'(FrameLen - 1);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic at_last;
    } t_status;

    // crc-16/ccitt-false over one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[sv/efcb_intf.sv]
// event input and frame byte output channel interfaces
`default_nettype none
interface efcb_evt_if;
    logic        valid;
    logic        ready;
    logic [31:0] sequence_number;
    logic [7:0]  event_type;
    logic [15:0] event_id;
    logic [31:0] value_bits;
    logic [31:0] event_flags;
    logic [63:0] payload_data;

    modport source (
        output valid, sequence_number, event_type, event_id, value_bits,
               event_flags, payload_data,
        input  ready
    );
    modport sink (
        input  valid, sequence_number, event_type, event_id, value_bits,
               event_flags, payload_data,
        output ready
    );
endinterface

interface efcb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface
`default_nettype wire

[sv/efcb_ctrl.sv]
// frame sequencer: accepts an event, then steps the datapath once per byte
`default_nettype none
module efcb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    input  efcb_pkg::t_status    i_status,
    output efcb_pkg::t_cmd       o_cmd
);
    import efcb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

[sv/efcb_dp.sv]
// frame store, byte position, running crc and output word register
`default_nettype none
module efcb_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  efcb_pkg::t_cmd       i_cmd,
    input  wire logic [31:0]     i_sequence_number,
    input  wire logic [7:0]      i_event_type,
    input  wire logic [15:0]     i_event_id,
    input  wire logic [31:0]     i_value_bits,
    input  wire logic [31:0]     i_event_flags,
    input  wire logic [63:0]     i_payload_data,
    output efcb_pkg::t_status    o_status,
    output logic [7:0]           o_frame_byte,
    output logic                 o_frame_last
);
    import efcb_pkg::*;

    logic [7:0]      r_frame [BodyLen];
    logic [PosW-1:0] r_pos, n_pos;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_byte, n_byte;
    logic            r_last;
    logic [7:0]      body_byte;
    logic            in_body;

    assign in_body           = (r_pos < POS_CRC_LO);
    assign body_byte         = in_body ? r_frame[r_pos] : 8'h00;
    assign o_status.at_last  = (r_pos == POS_LAST);
    assign o_frame_byte      = r_byte;
    assign o_frame_last      = r_last;

    // byte select and crc step
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_byte = r_byte;
        if (i_cmd.load) begin
            n_pos = '0;
            n_crc = CRC_INIT;
        end else if (i_cmd.emit) begin
            n_pos = o_status.at_last ? '0 : r_pos + 1'b1;
            if (in_body) begin
                n_byte = body_byte;
                n_crc  = crc_byte(r_crc, body_byte);
            end else if (r_pos == POS_CRC_LO) begin
                n_byte = r_crc[7:0];
            end else begin
                n_byte = r_crc[15:8];
            end
        end
    end

    // frame capture, one byte per entry in wire order
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame[0]  <= SYNC0;
            r_frame[1]  <= SYNC1;
            r_frame[2]  <= VERSION;
            r_frame[3]  <= PAYLOAD_LEN;
            r_frame[8]  <= i_event_type;
            r_frame[9]  <= 8'h00;
            r_frame[10] <= i_event_id[7:0];
            r_frame[11] <= i_event_id[15:8];
            for (int k = 0; k < 4; k++) begin
                r_frame[4 + k]  <= i_sequence_number[8*k +: 8];
                r_frame[12 + k] <= i_value_bits[8*k +: 8];
                r_frame[16 + k] <= i_event_flags[8*k +: 8];
            end
            for (int k = 0; k < 8; k++) begin
                r_frame[20 + k] <= i_payload_data[8*k +: 8];
            end
        end
    end

    // position and crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (i_cmd.emit) begin
            r_last <= o_status.at_last;
        end
    end

endmodule
`default_nettype wire

[sv/event_frame_crc16_builder.sv]
// Event frame builder with CRC-16/CCITT-FALSE trailer.
// Input channel i_evt (valid/ready) carries one event word: sequence
// number, type, identifier, value bits, flags and eight data bytes.
// Output channel o_frm (valid/ready) carries the 30-byte frame one byte per
// word: sync A5 5A, version, length 24, the little-endian event fields,
// the data bytes, then the CRC low and high bytes; frame_last marks the
// CRC high byte.
// Accepting an event captures it into the frame store; the sequencer then
// steps the bytes byte-serially through the crc and output register. With
// the receiver always ready, one byte leaves per cycle. i_evt.ready is high
// only while no frame is being sent; the final byte may still sit in the
// output register when the next event is taken.
// A stalled receiver holds the current byte in the output register and
// freezes the byte sequencer until the byte is taken.
// Synchronous active-low reset empties the output register and returns the
// block to idle; no frame in progress survives it.
`default_nettype none
module event_frame_crc16_builder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    efcb_evt_if.sink    i_evt,
    efcb_byte_if.source o_frm
);
    import efcb_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    efcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .i_out_ready (o_frm.ready),
        .o_out_valid (o_frm.valid),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    efcb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (s_cmd),
        .i_sequence_number (i_evt.sequence_number),
        .i_event_type      (i_evt.event_type),
        .i_event_id        (i_evt.event_id),
        .i_value_bits      (i_evt.value_bits),
        .i_event_flags     (i_evt.event_flags),
        .i_payload_data    (i_evt.payload_data),
        .o_status          (s_status),
        .o_frame_byte      (o_frm.frame_byte),
        .o_frame_last      (o_frm.frame_last)
    );

    // busy once an event is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("event accepted while frame in progress");

    // last position step puts a marked byte on the output
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.emit && s_status.at_last) |=> (o_frm.valid && o_frm.frame_last))
        else $error("final frame byte not marked");

    // a new frame never starts while bytes are still being stepped
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_cmd.load && s_cmd.emit))
        else $error("load and emit in the same cycle");

endmodule
`default_nettype wire
